>>> rtl/core/pee_pkg.sv
package pee_pkg;

   localparam int STACK_DEPTH_DEF = 128;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int SYMBOL_W        = 8;
   localparam int RESULT_W        = 32;

   localparam logic [SYMBOL_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [SYMBOL_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [SYMBOL_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CHAR_STAR    = 8'h2A;
   localparam logic [SYMBOL_W-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [SYMBOL_W-1:0] CHAR_PERCENT = 8'h25;

   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_MOD,
      KIND_OTHER
   } sym_kind_type;

   typedef enum logic [1:0] {
      UOP_MUL,
      UOP_DIV,
      UOP_MOD
   } unit_op_type;

   typedef enum logic [1:0] {
      PSRC_DIGIT,
      PSRC_ALU,
      PSRC_UNIT
   } push_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_LEFT,
      ST_OPERATE,
      ST_EXECUTE,
      ST_UNIT_WAIT,
      ST_END_POP,
      ST_END_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic         load_symbol;
      logic         push;
      push_src_type push_src;
      logic         pop;
      logic         cap_right;
      logic         cap_left;
      logic         set_div_err;
      logic         unit_start;
      logic         emit;
   } cmd_type;

   typedef struct packed {
      sym_kind_type kind;
      logic         div_err;
      logic         right_zero;
      logic         last;
      logic         unit_done;
      logic         out_free;
   } status_type;

   function automatic sym_kind_type classify(input logic [SYMBOL_W-1:0] c);
      sym_kind_type k;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         k = KIND_DIGIT;
      end else begin
         unique case (c)
            CHAR_PLUS:    k = KIND_ADD;
            CHAR_MINUS:   k = KIND_SUB;
            CHAR_STAR:    k = KIND_MUL;
            CHAR_SLASH:   k = KIND_DIV;
            CHAR_PERCENT: k = KIND_MOD;
            default:      k = KIND_OTHER;
         endcase
      end
      return k;
   endfunction

endpackage

>>> rtl/core/pee_if.sv
interface pee_req_if;
   logic                          valid;
   logic                          ready;
   logic [pee_pkg::SYMBOL_W-1:0]  symbol;
   logic                          last_symbol;

   modport source (output valid, output symbol, output last_symbol, input ready);
   modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface pee_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pee_pkg::RESULT_W-1:0] result_value;
   logic                                status;
   logic                                underflow_seen;
   logic                                overflow_seen;

   modport source (output valid, output result_value, output status,
                   output underflow_seen, output overflow_seen, input ready);
   modport sink   (input valid, input result_value, input status,
                   input underflow_seen, input overflow_seen, output ready);
endinterface

>>> rtl/core/pee_muldiv.sv
module pee_muldiv #(
   parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  pee_pkg::unit_op_type     op,
   input  logic [VALUE_WIDTH-1:0]   operand_a,
   input  logic [VALUE_WIDTH-1:0]   operand_b,
   output logic                     done,
   output logic [VALUE_WIDTH-1:0]   result
);

   localparam int HALF_W = (VALUE_WIDTH + 1) / 2;
   localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(2);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(VALUE_WIDTH - 1);

   logic                    busy_ff;
   logic                    done_ff;
   pee_pkg::unit_op_type    op_ff;
   logic [CNT_W-1:0]        step_ff;
   logic [VALUE_WIDTH-1:0]  a_ff;
   logic [VALUE_WIDTH-1:0]  b_ff;
   logic [VALUE_WIDTH-1:0]  acc_ff;
   logic                    neg_q_ff;
   logic                    neg_r_ff;

   logic                    last_step;
   logic [VALUE_WIDTH-1:0]  mag_a;
   logic [VALUE_WIDTH-1:0]  mag_b;
   logic [HALF_W-1:0]       mx;
   logic [HALF_W-1:0]       my;
   logic [2*HALF_W-1:0]     prod;
   logic [VALUE_WIDTH-1:0]  term;
   logic [VALUE_WIDTH-1:0]  rem_shift;
   logic                    fits;
   logic [VALUE_WIDTH-1:0]  rem_in;
   logic [VALUE_WIDTH-1:0]  a_in;

   assign last_step = (op_ff == pee_pkg::UOP_MUL) ? (step_ff == MUL_LAST)
                                                  : (step_ff == DIV_LAST);

   // magnitudes; the most negative value maps onto itself, read as unsigned
   assign mag_a = operand_a[VALUE_WIDTH-1] ? (~operand_a + 1'b1) : operand_a;
   assign mag_b = operand_b[VALUE_WIDTH-1] ? (~operand_b + 1'b1) : operand_b;

   // low word of the product from three half-width partial products
   always_comb begin
      mx = '0;
      my = '0;
      if (step_ff == CNT_W'(0)) begin
         mx = a_ff[HALF_W-1:0];
         my = b_ff[HALF_W-1:0];
      end else if (step_ff == CNT_W'(1)) begin
         mx[VALUE_WIDTH-HALF_W-1:0] = a_ff[VALUE_WIDTH-1:HALF_W];
         my = b_ff[HALF_W-1:0];
      end else begin
         mx = a_ff[HALF_W-1:0];
         my[VALUE_WIDTH-HALF_W-1:0] = b_ff[VALUE_WIDTH-1:HALF_W];
      end
   end

   assign prod = {{HALF_W{1'b0}}, mx} * {{HALF_W{1'b0}}, my};
   assign term = (step_ff == CNT_W'(0)) ? prod[VALUE_WIDTH-1:0]
                                        : (prod[VALUE_WIDTH-1:0] << HALF_W);

   // restoring divide step: remainder stays below the divisor, fits in W bits
   assign rem_shift = {acc_ff[VALUE_WIDTH-2:0], a_ff[VALUE_WIDTH-1]};
   assign fits      = (rem_shift >= b_ff);
   assign rem_in    = fits ? (rem_shift - b_ff) : rem_shift;
   assign a_in      = {a_ff[VALUE_WIDTH-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_step) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff   <= op;
         step_ff <= '0;
         acc_ff  <= '0;
         if (op == pee_pkg::UOP_MUL) begin
            a_ff <= operand_a;
            b_ff <= operand_b;
         end else begin
            a_ff <= mag_a;
            b_ff <= mag_b;
         end
         neg_q_ff <= operand_a[VALUE_WIDTH-1] ^ operand_b[VALUE_WIDTH-1];
         neg_r_ff <= operand_a[VALUE_WIDTH-1];
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (op_ff == pee_pkg::UOP_MUL) begin
            acc_ff <= acc_ff + term;
         end else begin
            acc_ff <= rem_in;
            a_ff   <= a_in;
         end
      end
   end

   always_comb begin
      unique case (op_ff)
         pee_pkg::UOP_MUL: result = acc_ff;
         pee_pkg::UOP_DIV: result = neg_q_ff ? (~a_ff + 1'b1) : a_ff;
         default:          result = neg_r_ff ? (~acc_ff + 1'b1) : acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule

>>> rtl/core/pee_datapath.sv
module pee_datapath #(
   parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pee_pkg::cmd_type                    cmd,
   output pee_pkg::status_type                 status,
   input  logic [pee_pkg::SYMBOL_W-1:0]        symbol,
   input  logic                                last_symbol,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pee_pkg::RESULT_W-1:0] rsp_result_value,
   output logic                                rsp_status,
   output logic                                rsp_underflow_seen,
   output logic                                rsp_overflow_seen
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int EXT_W  = (VALUE_WIDTH > pee_pkg::RESULT_W) ? VALUE_WIDTH
                                                             : pee_pkg::RESULT_W;

   logic [VALUE_WIDTH-1:0]        stack_mem [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0]        rdata_ff;

   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          pop_empty_ff;
   logic [pee_pkg::SYMBOL_W-1:0]  symbol_ff;
   logic                          last_ff;
   logic [VALUE_WIDTH-1:0]        right_ff;
   logic [VALUE_WIDTH-1:0]        left_ff;
   logic                          div_err_ff;
   logic                          under_ff;
   logic                          over_ff;

   logic                          out_valid_ff;
   logic [pee_pkg::RESULT_W-1:0]  out_value_ff;
   logic                          out_status_ff;
   logic                          out_under_ff;
   logic                          out_over_ff;

   pee_pkg::sym_kind_type         kind;
   pee_pkg::unit_op_type          unit_op;
   logic                          empty;
   logic                          full;
   logic [ADDR_W-1:0]             pop_addr;
   logic [VALUE_WIDTH-1:0]        popped;
   logic [VALUE_WIDTH-1:0]        alu_value;
   logic [VALUE_WIDTH-1:0]        digit_value;
   logic [VALUE_WIDTH-1:0]        push_value;
   logic [VALUE_WIDTH-1:0]        unit_result;
   logic                          unit_done;
   logic [EXT_W-1:0]              final_ext;
   logic                          out_free;

   assign kind     = pee_pkg::classify(symbol_ff);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign pop_addr = ADDR_W'(count_ff - 1'b1);
   assign popped   = pop_empty_ff ? '0 : rdata_ff;

   assign digit_value = {{(VALUE_WIDTH-4){1'b0}}, symbol_ff[3:0]};
   assign alu_value   = (kind == pee_pkg::KIND_SUB) ? (left_ff - right_ff)
                                                    : (left_ff + right_ff);

   always_comb begin
      unique case (kind)
         pee_pkg::KIND_MUL: unit_op = pee_pkg::UOP_MUL;
         pee_pkg::KIND_DIV: unit_op = pee_pkg::UOP_DIV;
         default:           unit_op = pee_pkg::UOP_MOD;
      endcase
   end

   always_comb begin
      unique case (cmd.push_src)
         pee_pkg::PSRC_DIGIT: push_value = digit_value;
         pee_pkg::PSRC_ALU:   push_value = alu_value;
         default:             push_value = unit_result;
      endcase
   end

   pee_muldiv #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.unit_start),
      .op        (unit_op),
      .operand_a (left_ff),
      .operand_b (right_ff),
      .done      (unit_done),
      .result    (unit_result)
   );

   // operand stack
   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= push_value;
      end
      if (cmd.pop && !empty) begin
         rdata_ff <= stack_mem[pop_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.emit) begin
         count_in = '0;
      end else if (cmd.push && !full) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop && !empty) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         div_err_ff <= 1'b0;
         under_ff   <= 1'b0;
         over_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.emit) begin
            div_err_ff <= 1'b0;
            under_ff   <= 1'b0;
            over_ff    <= 1'b0;
         end else begin
            if (cmd.set_div_err) div_err_ff <= 1'b1;
            if (cmd.pop && empty) under_ff <= 1'b1;
            if (cmd.push && full) over_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_symbol) begin
         symbol_ff <= symbol;
         last_ff   <= last_symbol;
      end
      if (cmd.pop) pop_empty_ff <= empty;
      if (cmd.cap_right) right_ff <= popped;
      if (cmd.cap_left) left_ff <= popped;
   end

   // result register: free when empty or when the sink is ready
   assign out_free  = !out_valid_ff || rsp_ready;
   assign final_ext = EXT_W'(popped);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_value_ff  <= div_err_ff ? '0 : final_ext[pee_pkg::RESULT_W-1:0];
         out_status_ff <= div_err_ff;
         out_under_ff  <= under_ff;
         out_over_ff   <= over_ff;
      end
   end

   assign status.kind       = kind;
   assign status.div_err    = div_err_ff;
   assign status.right_zero = (right_ff == '0);
   assign status.last       = last_ff;
   assign status.unit_done  = unit_done;
   assign status.out_free   = out_free;

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_value   = out_value_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_underflow_seen = out_under_ff;
   assign rsp_overflow_seen  = out_over_ff;

endmodule

>>> rtl/core/pee_controller.sv
module pee_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pee_pkg::status_type status,
   output pee_pkg::cmd_type    cmd
);

   pee_pkg::ctrl_state_type state_ff;
   pee_pkg::ctrl_state_type state_in;
   pee_pkg::ctrl_state_type after_symbol;

   assign after_symbol = status.last ? pee_pkg::ST_END_POP : pee_pkg::ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pee_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         pee_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_symbol = 1'b1;
               state_in        = pee_pkg::ST_DECODE;
            end
         end
         pee_pkg::ST_DECODE: begin
            if (status.div_err) begin
               state_in = after_symbol;
            end else if (status.kind == pee_pkg::KIND_DIGIT) begin
               cmd.push     = 1'b1;
               cmd.push_src = pee_pkg::PSRC_DIGIT;
               state_in     = after_symbol;
            end else begin
               cmd.pop  = 1'b1;
               state_in = pee_pkg::ST_POP_LEFT;
            end
         end
         pee_pkg::ST_POP_LEFT: begin
            cmd.cap_right = 1'b1;
            cmd.pop       = 1'b1;
            state_in      = pee_pkg::ST_OPERATE;
         end
         pee_pkg::ST_OPERATE: begin
            cmd.cap_left = 1'b1;
            state_in     = pee_pkg::ST_EXECUTE;
         end
         pee_pkg::ST_EXECUTE: begin
            unique case (status.kind)
               pee_pkg::KIND_ADD, pee_pkg::KIND_SUB: begin
                  cmd.push     = 1'b1;
                  cmd.push_src = pee_pkg::PSRC_ALU;
                  state_in     = after_symbol;
               end
               pee_pkg::KIND_MUL: begin
                  cmd.unit_start = 1'b1;
                  state_in       = pee_pkg::ST_UNIT_WAIT;
               end
               pee_pkg::KIND_DIV, pee_pkg::KIND_MOD: begin
                  if (status.right_zero) begin
                     cmd.set_div_err = 1'b1;
                     state_in        = after_symbol;
                  end else begin
                     cmd.unit_start = 1'b1;
                     state_in       = pee_pkg::ST_UNIT_WAIT;
                  end
               end
               default: begin
                  state_in = after_symbol;
               end
            endcase
         end
         pee_pkg::ST_UNIT_WAIT: begin
            if (status.unit_done) begin
               cmd.push     = 1'b1;
               cmd.push_src = pee_pkg::PSRC_UNIT;
               state_in     = after_symbol;
            end
         end
         pee_pkg::ST_END_POP: begin
            cmd.pop  = !status.div_err;
            state_in = pee_pkg::ST_END_EMIT;
         end
         pee_pkg::ST_END_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = pee_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pee_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/postfix_expression_evaluator_core.sv
// Postfix expression evaluator.
// req_if carries one ASCII character per transfer (symbol) plus last_symbol,
// which marks the end of an expression. rsp_if returns one transfer per
// expression: the popped top of stack, the divide-by-zero abort status and
// sticky underflow / overflow flags. Both use valid/ready; a transfer happens
// on a clock edge with valid and ready high.
// A digit is pushed; other characters pop the right, then the left operand.
// + and - push the alu result; * / % push the mul/div result (the divider
// gives one quotient bit per cycle); others and zero divisors push nothing.
// Stack reads are registered. A last character then pops and emits.
// One character is in work at a time; req ready is high only while idle.
// Results sit in an output register, so the next expression is taken while
// a result waits; if rsp stalls, the next result holds the block in its
// final step until the register frees.
// Reset (synchronous, active high) empties the stack and clears the flags;
// the stack memory itself is not cleared, no sweep is needed.
module postfix_expression_evaluator_core #(
   parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pee_req_if.sink       req_if,
   pee_rsp_if.source     rsp_if
);

   // command and status between the sequencer and the datapath
   pee_pkg::cmd_type    cmd;
   pee_pkg::status_type status;

   // sequencer: one character at a time, pops, operate, push, final emit
   pee_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stack memory, operand registers, alu, mul/div unit, result register
   pee_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .symbol             (req_if.symbol),
      .last_symbol        (req_if.last_symbol),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_result_value   (rsp_if.result_value),
      .rsp_status         (rsp_if.status),
      .rsp_underflow_seen (rsp_if.underflow_seen),
      .rsp_overflow_seen  (rsp_if.overflow_seen)
   );

endmodule
